// File: hdl/dll_pkg.sv
// ---------------------------------------------------------------------------
// Linked list engine package
// Shared types, constants and helpers for the circular doubly linked list.
// ---------------------------------------------------------------------------
package dll_pkg;

	localparam int unsigned NODE_COUNT = 64;
	localparam int unsigned DEPTH = NODE_COUNT + 1;
	localparam int unsigned LINK_W = $clog2(NODE_COUNT + 2);
	localparam int unsigned ADDR_W = $clog2(NODE_COUNT + 1);
	localparam int unsigned NODE_W = 7;

	typedef logic [LINK_W-1:0] link_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam link_t ANCHOR = link_t'(0);
	localparam link_t LINK_NULL = link_t'(NODE_COUNT + 1);

	typedef enum logic [1:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_REMOVE
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_INVALID,
		STAT_BUSY,
		STAT_NOT_FOUND
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_LINK,
		S_WRITE
	} fsm_t;

	typedef struct packed {
		op_t              operation;
		logic [NODE_W-1:0] node_index;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [NODE_W-1:0] popped_node;
		logic              list_empty;
	} rsp_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		link_t data;
	} wr_t;

	typedef struct packed {
		wr_t   wr;
		addr_t rd_addr_a;
		addr_t rd_addr_b;
	} mem_req_t;

	typedef struct packed {
		link_t rd_a;
		link_t rd_b;
	} mem_rsp_t;

	function automatic logic is_node(input link_t x);
		return x <= link_t'(NODE_COUNT);
	endfunction

	function automatic addr_t to_addr(input link_t x);
		return is_node(x) ? addr_t'(x) : addr_t'(0);
	endfunction

endpackage

// File: hdl/dll_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ---------------------------------------------------------------------------
module dll_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// File: hdl/dll_link_mem.sv
// ---------------------------------------------------------------------------
// Link memory
// One link table with a valid bit per entry; unwritten entries read as null.
// ---------------------------------------------------------------------------
module dll_link_mem (
	input  logic               clk,
	input  logic               arst_n,
	input  dll_pkg::mem_req_t  req,
	output dll_pkg::mem_rsp_t  rsp
);

	import dll_pkg::*;

	logic [DEPTH-1:0] vld_q;
	logic             vld_a_s1;
	logic             vld_b_s1;
	link_t            ram_a;
	link_t            ram_b;

	dll_ram #(
		.WIDTH(LINK_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (req.wr.en),
		.waddr   (req.wr.addr),
		.wdata   (req.wr.data),
		.raddr_a (req.rd_addr_a),
		.raddr_b (req.rd_addr_b),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_a_s1 <= 1'b0;
			vld_b_s1 <= 1'b0;
		end else begin
			if (req.wr.en) begin
				vld_q[req.wr.addr] <= 1'b1;
			end
			vld_a_s1 <= vld_q[req.rd_addr_a];
			vld_b_s1 <= vld_q[req.rd_addr_b];
		end
	end

	assign rsp.rd_a = vld_a_s1 ? ram_a : LINK_NULL;
	assign rsp.rd_b = vld_b_s1 ? ram_b : LINK_NULL;

endmodule

// File: hdl/dll_ctrl.sv
// ---------------------------------------------------------------------------
// Linked list sequencer
// Reads the node and neighbor links, checks them and writes the new links.
// ---------------------------------------------------------------------------
module dll_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dll_pkg::req_t     request,
	output logic              busy,
	output logic              done,
	output dll_pkg::rsp_t     result,
	output dll_pkg::mem_req_t fwd_req,
	input  dll_pkg::mem_rsp_t fwd_rsp,
	output dll_pkg::mem_req_t bwd_req,
	input  dll_pkg::mem_rsp_t bwd_rsp
);

	import dll_pkg::*;

	fsm_t    state_q, state_d;
	op_t     op_q;
	link_t   e_q;
	logic    bad_q;
	link_t   anc_f_q, anc_f_d;
	link_t   anc_b_q, anc_b_d;
	link_t   prev_q, prev_d;
	link_t   next_q, next_d;
	wr_t     f2_q, f2_d;
	wr_t     b2_q, b2_d;
	logic    done_q;
	rsp_t    result_q;

	link_t   e_in;
	logic    bad_in;
	link_t   fe, be, fpn, bnx, fp, bn;
	logic    e_linked;
	status_t ck_status;
	logic    ck_go_link;
	logic    lk_ok;
	logic    fin;
	status_t fin_status;
	logic [NODE_W-1:0] fin_popped;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;

	assign e_in = (request.operation == OP_POP_FRONT) ? anc_f_q : link_t'(request.node_index);
	assign bad_in = (request.node_index > NODE_W'(NODE_COUNT)) || (request.node_index == '0);

	always_comb begin
		fe = fwd_rsp.rd_a;
		be = bwd_rsp.rd_a;
		fpn = (anc_b_q == ANCHOR) ? anc_f_q : fwd_rsp.rd_b;
		bnx = (anc_f_q == ANCHOR) ? anc_b_q : bwd_rsp.rd_b;
		fp = (prev_q == ANCHOR) ? anc_f_q : fwd_rsp.rd_b;
		bn = (next_q == ANCHOR) ? anc_b_q : bwd_rsp.rd_b;
		e_linked = (fe != LINK_NULL) || (be != LINK_NULL);
		lk_ok = (fp == e_q) && (bn == e_q);
		ck_status = STAT_OK;
		ck_go_link = 1'b0;
		unique case (op_q)
			OP_PUSH_FRONT: begin
				if (bad_q || !is_node(anc_f_q)) begin
					ck_status = STAT_INVALID;
				end else if (e_linked) begin
					ck_status = STAT_BUSY;
				end else if (bnx != ANCHOR) begin
					ck_status = STAT_INVALID;
				end
			end
			OP_PUSH_BACK: begin
				if (bad_q || !is_node(anc_b_q)) begin
					ck_status = STAT_INVALID;
				end else if (e_linked) begin
					ck_status = STAT_BUSY;
				end else if (fpn != ANCHOR) begin
					ck_status = STAT_INVALID;
				end
			end
			OP_POP_FRONT: begin
				if (!is_node(e_q)) begin
					ck_status = STAT_INVALID;
				end else if (e_q == ANCHOR) begin
					ck_status = STAT_NOT_FOUND;
				end else if (!is_node(be) || !is_node(fe)) begin
					ck_status = STAT_NOT_FOUND;
				end else begin
					ck_go_link = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (bad_q) begin
					ck_status = STAT_INVALID;
				end else if (!is_node(be) || !is_node(fe)) begin
					ck_status = STAT_NOT_FOUND;
				end else begin
					ck_go_link = 1'b1;
				end
			end
			default: begin
				ck_status = STAT_INVALID;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (ck_go_link) begin
					state_d = S_LINK;
				end else if (ck_status == STAT_OK) begin
					state_d = S_WRITE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LINK: begin
				state_d = lk_ok ? S_WRITE : S_IDLE;
			end
			S_WRITE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		fwd_req = '0;
		bwd_req = '0;
		fwd_req.rd_addr_a = to_addr(e_q);
		bwd_req.rd_addr_a = to_addr(e_q);
		fwd_req.rd_addr_b = to_addr(anc_b_q);
		bwd_req.rd_addr_b = to_addr(anc_f_q);
		anc_f_d = anc_f_q;
		anc_b_d = anc_b_q;
		prev_d = prev_q;
		next_d = next_q;
		f2_d = '0;
		b2_d = '0;
		fin = 1'b0;
		fin_status = STAT_OK;
		fin_popped = '0;
		unique case (state_q)
			S_IDLE: begin
				fwd_req.rd_addr_a = to_addr(e_in);
				bwd_req.rd_addr_a = to_addr(e_in);
			end
			S_CHECK: begin
				fwd_req.rd_addr_b = to_addr(be);
				bwd_req.rd_addr_b = to_addr(fe);
				if (ck_status != STAT_OK) begin
					fin = 1'b1;
					fin_status = ck_status;
				end else if (ck_go_link) begin
					prev_d = be;
					next_d = fe;
				end else if (op_q == OP_PUSH_FRONT) begin
					fwd_req.wr = '{en: 1'b1, addr: to_addr(e_q), data: anc_f_q};
					bwd_req.wr = '{en: 1'b1, addr: to_addr(e_q), data: ANCHOR};
					anc_f_d = e_q;
					if (anc_f_q == ANCHOR) begin
						anc_b_d = e_q;
					end else begin
						b2_d = '{en: 1'b1, addr: to_addr(anc_f_q), data: e_q};
					end
				end else begin
					fwd_req.wr = '{en: 1'b1, addr: to_addr(e_q), data: ANCHOR};
					bwd_req.wr = '{en: 1'b1, addr: to_addr(e_q), data: anc_b_q};
					anc_b_d = e_q;
					if (anc_b_q == ANCHOR) begin
						anc_f_d = e_q;
					end else begin
						f2_d = '{en: 1'b1, addr: to_addr(anc_b_q), data: e_q};
					end
				end
			end
			S_LINK: begin
				if (!lk_ok) begin
					fin = 1'b1;
					fin_status = STAT_INVALID;
				end else begin
					if (prev_q == ANCHOR) begin
						anc_f_d = next_q;
					end else begin
						fwd_req.wr = '{en: 1'b1, addr: to_addr(prev_q), data: next_q};
					end
					if (next_q == ANCHOR) begin
						anc_b_d = prev_q;
					end else begin
						bwd_req.wr = '{en: 1'b1, addr: to_addr(next_q), data: prev_q};
					end
					f2_d = '{en: 1'b1, addr: to_addr(e_q), data: LINK_NULL};
					b2_d = '{en: 1'b1, addr: to_addr(e_q), data: LINK_NULL};
				end
			end
			S_WRITE: begin
				fwd_req.wr = f2_q;
				bwd_req.wr = b2_q;
				fin = 1'b1;
				fin_status = STAT_OK;
				if (op_q == OP_POP_FRONT) begin
					fin_popped = NODE_W'(e_q);
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			anc_f_q <= ANCHOR;
			anc_b_q <= ANCHOR;
			f2_q    <= '0;
			b2_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			anc_f_q <= anc_f_d;
			anc_b_q <= anc_b_d;
			f2_q    <= f2_d;
			b2_q    <= b2_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q  <= request.operation;
			e_q   <= e_in;
			bad_q <= bad_in;
		end
		prev_q <= prev_d;
		next_q <= next_d;
		if (fin) begin
			result_q <= '{status: fin_status, popped_node: fin_popped,
				list_empty: (anc_f_q == ANCHOR)};
		end
	end

endmodule

// File: hdl/doubly_linked_list_engine_top.sv
// ---------------------------------------------------------------------------
// Doubly linked list engine
// Circular doubly linked list over a fixed pool of node indices.
// ---------------------------------------------------------------------------
// A command is transferred at a rising edge where start is high and busy is
// low; it carries the operation and the node index. Busy stays high until
// the result is out. Each command gives exactly one result, shown on the
// result port for one cycle while done is high; the receiver cannot stall
// it and must take it in that cycle.
// A push passes through the check and write states, a pop or remove through
// the check, link and write states, and a rejected command ends in the check
// or link state. The cost is set by the link memories: one read round for the
// node, a second for the neighbors of a removed node, and writes split over the
// check or link state and the write state; each table has one write port.
// Reset leaves an empty list: the anchor links point to the anchor and
// every node is unlinked. The per-entry valid bits clear at once, so the
// block takes a command in the first cycle after reset.
// ---------------------------------------------------------------------------
module doubly_linked_list_engine_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dll_pkg::req_t  request,
	output logic           busy,
	output logic           done,
	output dll_pkg::rsp_t  result
);

	import dll_pkg::*;

	mem_req_t fwd_req;
	mem_rsp_t fwd_rsp;
	mem_req_t bwd_req;
	mem_rsp_t bwd_rsp;

	dll_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.fwd_req (fwd_req),
		.fwd_rsp (fwd_rsp),
		.bwd_req (bwd_req),
		.bwd_rsp (bwd_rsp)
	);

	dll_link_mem u_fwd_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fwd_req),
		.rsp    (fwd_rsp)
	);

	dll_link_mem u_bwd_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bwd_req),
		.rsp    (bwd_rsp)
	);

endmodule

// File: hdl/dll_checker.sv
// ---------------------------------------------------------------------------
// Linked list engine checker
// Port-level checks on command and result timing and on the popped node, bound to the top level.
// ---------------------------------------------------------------------------
module dll_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input dll_pkg::req_t request,
	input logic          busy,
	input logic          done,
	input dll_pkg::rsp_t result
);

	import dll_pkg::*;

	logic unused_req;

	assign unused_req = ^request;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a command is still in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("transfer not followed by a busy cycle");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("command finished without a result");

	a_popped_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_OK) |-> (result.popped_node == '0))
		else $error("popped node reported on a failed command");

endmodule

bind doubly_linked_list_engine_top dll_checker u_chk (.*);
